FILE: hdl/sssd_pkg.sv
// Shared types, constants and tables for the seven-segment serial display.
// Used by sssd_ctrl, sssd_datapath and seven_segment_serial_display.
package sssd_pkg;

  // Number of digit slots shown (1 to 4)
  localparam int DIGIT_COUNT = 4;
  // Largest value the digits can show
  localparam int MAX_SHOWN   = (10 ** DIGIT_COUNT) - 1;
  // Slot of the last byte in a frame and top slot of the extraction
  localparam logic [1:0] SLOT_LAST = 2'(DIGIT_COUNT - 1);
  // Largest decimal digit
  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [2:0] BIT_LAST  = 3'd7;

  // Register indexes
  typedef enum logic {
    REG_SLOT_ORDER  = 1'b0,
    REG_HALF_PERIOD = 1'b1
  } sssd_reg_t;

  localparam logic [9:0] HALF_PERIOD_RESET = 10'd32;

  // Controller to datapath commands
  typedef struct packed {
    logic load;         // capture and saturate the request value
    logic sub;          // subtract current power of ten
    logic store_digit;  // store digit, step to next lower slot
    logic emit;         // load next bit into the output register
  } sssd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sub_ok;     // remainder covers one more power and digit below 9
    logic ext_last;   // extracting slot 0
    logic out_free;   // output register can take a bit this cycle
    logic send_last;  // next bit is the last of the frame
  } sssd_status_t;

  // Power of ten for a digit slot
  function automatic logic [13:0] tens_power(input logic [1:0] slot);
    logic [13:0] p;
    case (slot)
      2'd0:    p = 14'd1;
      2'd1:    p = 14'd10;
      2'd2:    p = 14'd100;
      2'd3:    p = 14'd1000;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

  // Segment byte: A at bit 0 through G at bit 6
  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] s;
    case (digit)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h27;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

FILE: hdl/sssd_ctrl.sv
// Controller state machine: accepts a request, steps digit extraction, then
// paces the serial bits. Depends on sssd_pkg for command and status types.
module sssd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sssd_pkg::sssd_status_t status,
  output sssd_pkg::sssd_cmd_t    cmd
);
  import sssd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_EXTRACT = 3'b010,
    ST_SEND    = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        // no request is taken while in reset
        in_stall = rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_EXTRACT;
        end
      end
      ST_EXTRACT: begin
        if (status.sub_ok) begin
          cmd.sub = 1'b1;
        end else begin
          cmd.store_digit = 1'b1;
          if (status.ext_last) state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.send_last) state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/sssd_datapath.sv
// Datapath: saturation, subtract-based digit extraction, digit store,
// segment lookup and the output register. Depends on sssd_pkg.
module sssd_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  sssd_pkg::sssd_cmd_t    cmd,
  output sssd_pkg::sssd_status_t status,
  input  logic                   slot_order,
  input  logic [15:0]            value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   segment_bit,
  output logic [1:0]             digit_slot,
  output logic [2:0]             bit_index,
  output logic                   overflow,
  output logic                   frame_end
);
  import sssd_pkg::*;

  logic [13:0] remainder_value;
  logic [3:0]  digit;
  logic [1:0]  ext_slot;
  logic        ovf;
  logic [3:0]  digit_store [4];
  logic [1:0]  send_count;
  logic [2:0]  bit_count;

  logic [13:0] power;
  logic [1:0]  send_slot;
  logic [7:0]  segments;
  logic        saturate;
  logic        last_bit;

  assign power     = tens_power(ext_slot);
  assign saturate  = value > 16'(MAX_SHOWN);
  assign send_slot = slot_order ? send_count : SLOT_LAST - send_count;
  assign segments  = seg_pattern(digit_store[send_slot]);
  assign last_bit  = (send_count == SLOT_LAST) && (bit_count == BIT_LAST);

  assign status.sub_ok    = (remainder_value >= power) && (digit != DIGIT_MAX);
  assign status.ext_last  = (ext_slot == 2'd0);
  assign status.out_free  = !out_valid || !out_stall;
  assign status.send_last = last_bit;

  // Extraction: one subtraction per cycle, one store per digit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      remainder_value <= saturate ? 14'(MAX_SHOWN) : value[13:0];
      ovf             <= saturate;
      digit           <= '0;
      ext_slot        <= SLOT_LAST;
    end else if (cmd.sub) begin
      remainder_value <= remainder_value - power;
      digit           <= digit + 4'd1;
    end else if (cmd.store_digit) begin
      digit_store[ext_slot] <= digit;
      digit                 <= '0;
      ext_slot              <= ext_slot - 2'd1;
    end
  end

  // Send counters
  always_ff @(posedge clk) begin
    if (rst) begin
      send_count <= '0;
      bit_count  <= '0;
    end else if (cmd.load) begin
      send_count <= '0;
      bit_count  <= '0;
    end else if (cmd.emit) begin
      bit_count <= bit_count + 3'd1;
      if (bit_count == BIT_LAST) send_count <= send_count + 2'd1;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      segment_bit <= segments[bit_count];
      digit_slot  <= send_slot;
      bit_index   <= bit_count;
      overflow    <= ovf;
      frame_end   <= last_bit;
    end
  end

endmodule

FILE: hdl/seven_segment_serial_display.sv
// Top level of the seven-segment serial display: configuration registers,
// controller and datapath. Depends on sssd_pkg, sssd_ctrl, sssd_datapath.
//
// Each request carries a 16-bit value; values above 9999 show as 9999 with
// overflow set on every bit of the frame. The value is split into four
// decimal digits by a single shared subtractor, one subtraction per cycle
// plus a separate store step per digit. The 32 segment bits
// (segment A first within each byte) then leave through a one-bit output
// register at one per cycle while the output is not stalled, the last one
// flagged frame_end. The next request is accepted once the last bit has been
// loaded into the output register. slot_order = 1 sends slot 0 (units)
// first, 0 sends the top slot first. half_period_cycles is held for the
// downstream pin driver that generates shift clock and strobe; it does not
// change the bit stream. Registers: 0 slot_order, 4 half_period_cycles.
module seven_segment_serial_display (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] value,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        segment_bit,
  output logic [1:0]  digit_slot,
  output logic [2:0]  bit_index,
  output logic        overflow,
  output logic        frame_end
);
  import sssd_pkg::*;

  logic         slot_order;
  logic [9:0]   half_period_cycles;
  logic         cfg_write;
  sssd_reg_t    reg_sel;
  sssd_cmd_t    cmd;
  sssd_status_t status;

  assign pready    = 1'b1;
  assign reg_sel   = sssd_reg_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_order         <= 1'b0;
      half_period_cycles <= HALF_PERIOD_RESET;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_SLOT_ORDER:  slot_order         <= pwdata[0];
        REG_HALF_PERIOD: half_period_cycles <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (reg_sel)
      REG_SLOT_ORDER:  prdata = {31'd0, slot_order};
      REG_HALF_PERIOD: prdata = {22'd0, half_period_cycles};
      default:         prdata = '0;
    endcase
  end

  sssd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sssd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .slot_order  (slot_order),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .segment_bit (segment_bit),
    .digit_slot  (digit_slot),
    .bit_index   (bit_index),
    .overflow    (overflow),
    .frame_end   (frame_end)
  );

endmodule

FILE: sim/tb_seven_segment_serial_display.sv
`timescale 1ns / 1ps
// Self-checking testbench for seven_segment_serial_display: directed table, then random
// requests, each frame's 32 serial bits checked against table fonts or a local predictor.
// Depends on sssd_pkg and the seven_segment_serial_display RTL.
module tb_seven_segment_serial_display;
  import sssd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;
  localparam int PHASE_ITEMS    = 65;
  localparam int DIR_N          = 25;

  // One serial bit as it leaves the block
  typedef struct packed {
    logic       seg;
    logic [1:0] slot;
    logic [2:0] idx;
    logic       ovf;
    logic       last;
  } serial_bit_t;

  // Directed row: fonts are the four segment bytes, slot 3 in the top byte
  typedef struct packed {
    logic [15:0] val;
    logic        order;
    logic        typed;
    logic [31:0] fonts;
    logic        ovf;
  } dir_row_t;

  // Segment bytes for digits 0..9, A at bit 0
  localparam logic [7:0] SEG_FONT [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h27, 8'h7F, 8'h6F
  };

  localparam logic [15:0] EDGE_VALUES [10] = '{
    16'd0, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000, 16'd9999,
    16'd10000, 16'hFFFF
  };

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{16'd0,     1'b0, 1'b1, 32'h3F3F3F3F, 1'b0},
    '{16'd9999,  1'b0, 1'b1, 32'h6F6F6F6F, 1'b0},
    '{16'd10000, 1'b0, 1'b1, 32'h6F6F6F6F, 1'b1},
    '{16'd65535, 1'b0, 1'b1, 32'h6F6F6F6F, 1'b1},
    '{16'd1234,  1'b0, 1'b0, 32'h0,        1'b0},
    '{16'd8888,  1'b0, 1'b1, 32'h7F7F7F7F, 1'b0},
    '{16'd1111,  1'b0, 1'b1, 32'h06060606, 1'b0},
    '{16'd5,     1'b0, 1'b0, 32'h0,        1'b0},
    '{16'd90,    1'b0, 1'b0, 32'h0,        1'b0},
    '{16'd700,   1'b0, 1'b0, 32'h0,        1'b0},
    '{16'd1,     1'b0, 1'b0, 32'h0,        1'b0},
    '{16'd32768, 1'b0, 1'b1, 32'h6F6F6F6F, 1'b1},
    '{16'd4321,  1'b0, 1'b0, 32'h0,        1'b0},
    '{16'd9990,  1'b0, 1'b0, 32'h0,        1'b0},
    '{16'd0,     1'b1, 1'b1, 32'h3F3F3F3F, 1'b0},
    '{16'd65535, 1'b1, 1'b1, 32'h6F6F6F6F, 1'b1},
    '{16'd1234,  1'b1, 1'b0, 32'h0,        1'b0},
    '{16'd7777,  1'b1, 1'b1, 32'h27272727, 1'b0},
    '{16'd6543,  1'b1, 1'b0, 32'h0,        1'b0},
    '{16'd10,    1'b1, 1'b0, 32'h0,        1'b0},
    '{16'd99,    1'b1, 1'b0, 32'h0,        1'b0},
    '{16'd100,   1'b1, 1'b0, 32'h0,        1'b0},
    '{16'd999,   1'b1, 1'b0, 32'h0,        1'b0},
    '{16'd1000,  1'b1, 1'b0, 32'h0,        1'b0},
    '{16'd9998,  1'b1, 1'b0, 32'h0,        1'b0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        segment_bit;
  logic [1:0]  digit_slot;
  logic [2:0]  bit_index;
  logic        overflow;
  logic        frame_end;

  // Local copy of the register state
  logic        order_cfg = 1'b0;
  logic [9:0]  half_cfg  = HALF_PERIOD_RESET;

  serial_bit_t pending_bits[$];
  int fail_count = 0;
  int values_sent = 0;
  int saturated_sent = 0;
  int bits_checked = 0;
  int settings_used = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  bit long_hold_pending = 1'b0;
  bit long_hold_done = 1'b0;

  seven_segment_serial_display u_top (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .segment_bit (segment_bit),
    .digit_slot  (digit_slot),
    .bit_index   (bit_index),
    .overflow    (overflow),
    .frame_end   (frame_end)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Queue the serial bits of one frame in send order
  task automatic expand_frame(input logic [31:0] fonts, input logic ovf);
    int slot;
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      slot = order_cfg ? k : DIGIT_COUNT - 1 - k;
      for (int b = 0; b < 8; b++) begin
        pending_bits.push_back('{fonts[8 * slot + b], 2'(slot), 3'(b), ovf,
                                 (k == DIGIT_COUNT - 1) && (b == 7)});
      end
    end
  endtask

  // Saturate, split into decimal digits, look up segment bytes
  task automatic predict_display(input logic [15:0] v);
    int rest;
    logic ovf;
    logic [31:0] fonts;
    rest = v;
    ovf = 1'b0;
    fonts = '0;
    if (rest > MAX_SHOWN) begin
      rest = MAX_SHOWN;
      ovf = 1'b1;
    end
    for (int s = 0; s < DIGIT_COUNT; s++) begin
      fonts[8 * s +: 8] = SEG_FONT[rest % 10];
      rest = rest / 10;
    end
    expand_frame(fonts, ovf);
  endtask

  // APB access: setup phase, access phase until pready, then back to idle
  task automatic reg_access(input sssd_reg_t r, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register, read it back, track the kept bits
  task automatic cfg_set(input sssd_reg_t r, input logic [31:0] wdata);
    logic [31:0] kept;
    logic [31:0] rd;
    kept = (r == REG_SLOT_ORDER) ? (wdata & 32'h1) : (wdata & 32'h3FF);
    reg_access(r, 1'b1, wdata, rd);
    reg_access(r, 1'b0, '0, rd);
    check_field(r == REG_SLOT_ORDER ? "slot_order" : "half_period_cycles", kept, rd);
    if (r == REG_SLOT_ORDER) order_cfg = kept[0];
    else half_cfg = kept[9:0];
  endtask

  // Offer one request, with random bursts and gaps; returns at acceptance
  task automatic offer(input logic [15:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!(long_hold_pending && !long_hold_done)) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_stall);
    values_sent++;
    if (v > MAX_SHOWN) saturated_sent++;
  endtask

  // Stop offering and wait until every expected bit has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_bits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      6:       v = 16'($urandom_range(MAX_SHOWN + 1, 65535));
      7:       v = 16'($urandom());
      8:       v = 16'($urandom_range(0, 99));
      9:       v = EDGE_VALUES[$urandom_range(0, 9)];
      default: v = 16'($urandom_range(0, MAX_SHOWN));
    endcase
    return v;
  endfunction

  // Result checker: compare each accepted bit with the oldest expectation
  always @(posedge clk) begin
    serial_bit_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_bits.size() == 0) begin
        $error("serial bit with no request pending: slot %0d index %0d",
               digit_slot, bit_index);
        fail_count++;
      end else begin
        e = pending_bits.pop_front();
        check_field("segment_bit", e.seg, segment_bit);
        check_field("digit_slot", e.slot, digit_slot);
        check_field("bit_index", e.idx, bit_index);
        check_field("overflow", e.ovf, overflow);
        check_field("frame_end", e.last, frame_end);
        bits_checked++;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
      $display("seven_segment_serial_display regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stretches of no stall, light, half and heavy stall, plus one long hold
  initial begin
    int mode;
    int span;
    wait (!rst);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(1, 150);
      repeat (span) begin
        @(posedge clk);
        if (long_hold_pending && !long_hold_done) begin
          out_stall <= 1'b1;
          repeat (LONG_HOLD) @(posedge clk);
          long_hold_done = 1'b1;
        end
        case (mode)
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          3:       out_stall <= ($urandom_range(0, 1) == 0);
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Main sequence
  initial begin
    logic [31:0] rd;
    logic [31:0] hp;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values
    reg_access(REG_SLOT_ORDER, 1'b0, '0, rd);
    check_field("slot_order", 0, rd);
    reg_access(REG_HALF_PERIOD, 1'b0, '0, rd);
    check_field("half_period_cycles", HALF_PERIOD_RESET, rd);

    // wide write keeps only bit 0; half period of zero is stored as is
    cfg_set(REG_SLOT_ORDER, 32'hFFFF_FFFE);
    cfg_set(REG_HALF_PERIOD, 32'h0);
    settings_used++;

    // directed table
    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_ROWS[i].order != order_cfg) begin
        drain_results();
        cfg_set(REG_SLOT_ORDER, 32'hA5A5_5A5B);
        cfg_set(REG_HALF_PERIOD, 32'hFFFF_FFFF);
        settings_used++;
      end
      offer(DIR_ROWS[i].val);
      if (DIR_ROWS[i].typed) expand_frame(DIR_ROWS[i].fonts, DIR_ROWS[i].ovf);
      else predict_display(DIR_ROWS[i].val);
    end

    // random phases, each under its own register setting
    for (int p = 0; p < 4; p++) begin
      drain_results();
      case (p)
        0: begin
          cfg_set(REG_SLOT_ORDER, 32'h0);
          cfg_set(REG_HALF_PERIOD, 32'h1);
        end
        1: begin
          hp = $urandom_range(2, 1022);
          cfg_set(REG_SLOT_ORDER, 32'hFFFF_FFFF);
          cfg_set(REG_HALF_PERIOD, ($urandom() & ~32'h3FF) | hp);
        end
        2: begin
          cfg_set(REG_SLOT_ORDER, 32'h8000_0002);
          cfg_set(REG_HALF_PERIOD, 32'h0000_03FF);
        end
        default: begin
          cfg_set(REG_SLOT_ORDER, 32'h1);
          cfg_set(REG_HALF_PERIOD, $urandom());
        end
      endcase
      settings_used++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold the receiver off while requests keep coming
        if (p == 1 && n == 20) long_hold_pending = 1'b1;
        hp = {16'd0, pick_value()};
        offer(hp[15:0]);
        predict_display(hp[15:0]);
      end
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (pending_bits.size() != 0) begin
      $error("%0d serial bits never arrived", pending_bits.size());
      fail_count++;
    end

    $display("Sent %0d values (%0d above %0d) under %0d register settings;",
             values_sent, saturated_sent, MAX_SHOWN, settings_used);
    $display("checked %0d serial bits, with one long receiver hold.", bits_checked);
    if (fail_count == 0) begin
      $display("seven_segment_serial_display regression: pass");
    end else begin
      $display("seven_segment_serial_display regression: fail");
    end
    $finish;
  end

endmodule
